### rtl/cbq_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded biquad filter package
// Item types, fixed-point widths, control word format and the microcode
// program shared by the sequencer, the datapath and the top level.
// ----------------------------------------------------------------------------
package cbq_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int STAGES_DEFAULT = 4;
    localparam int COEF_BITS      = 32;
    localparam int COEF_PER_STAGE = 5;
    localparam int CIDX_BITS      = 5;
    localparam int WORD_BITS      = 48;
    localparam int INT_FRAC       = 40 - SAMPLE_BITS;
    localparam int HALF_BITS      = 25;
    localparam int SPLIT_BITS     = 24;
    localparam int MUL_BITS       = COEF_BITS + HALF_BITS;
    localparam int FULL_BITS      = 80;
    localparam int COEF_FRAC      = 30;
    localparam int TERM_BITS      = FULL_BITS - COEF_FRAC;
    localparam int ACC_BITS       = 52;
    localparam int STEP_BITS      = 4;

    localparam logic [STEP_BITS-1:0] STEP_STAGE_START = STEP_BITS'(0);

    typedef enum logic
    {
        ACT_SAMPLE = 1'b0,
        ACT_COEF   = 1'b1
    } action_t;

    typedef struct packed
    {
        logic                           action;
        logic signed [SAMPLE_BITS-1:0]  sample_in;
        logic [CIDX_BITS-1:0]           coef_index;
        logic signed [COEF_BITS-1:0]    coef_value;
        logic                           block_end;
    } in_item_t;

    typedef struct packed
    {
        logic signed [SAMPLE_BITS-1:0]  sample_out;
        logic                           clipped;
        logic                           block_end_out;
    } out_item_t;

    typedef enum logic [2:0]
    {
        POS_B0 = 3'd0,
        POS_B1 = 3'd1,
        POS_B2 = 3'd2,
        POS_A1 = 3'd3,
        POS_A2 = 3'd4
    } coef_pos_t;

    typedef enum logic [1:0]
    {
        SRC_W1 = 2'd0,
        SRC_W2 = 2'd1,
        SRC_W  = 2'd2
    } src_t;

    typedef enum logic [2:0]
    {
        ACC_HOLD   = 3'd0,
        ACC_LOAD_V = 3'd1,
        ACC_ZERO   = 3'd2,
        ACC_ADD    = 3'd3,
        ACC_SUB    = 3'd4
    } acc_op_t;

    typedef enum logic [1:0]
    {
        JMP_NEXT = 2'd0,
        JMP_LOOP = 2'd1,
        JMP_END  = 2'd2
    } jump_t;

    typedef enum logic
    {
        SEQ_IDLE = 1'b0,
        SEQ_RUN  = 1'b1
    } seq_state_t;

    typedef struct packed
    {
        logic                  mul_en;
        logic                  mul_hi;
        coef_pos_t             pos;
        src_t                  src;
        logic                  lo_en;
        logic                  sum_en;
        acc_op_t               acc_op;
        logic                  w_sat;
        logic                  stage_end;
        jump_t                 jump;
        logic [STEP_BITS-1:0]  target;
    } ucode_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } seq_status_t;

    localparam ucode_t UCODE_NOP = '{
        mul_en:    1'b0,
        mul_hi:    1'b0,
        pos:       POS_B0,
        src:       SRC_W1,
        lo_en:     1'b0,
        sum_en:    1'b0,
        acc_op:    ACC_HOLD,
        w_sat:     1'b0,
        stage_end: 1'b0,
        jump:      JMP_NEXT,
        target:    STEP_STAGE_START
    };

    // One stage takes steps 0 to 12; step 13 delivers the result.
    // Each product passes the multiplier as a low then a high half, then the
    // final add and the accumulator, so consecutive products overlap.
    function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
        ucode_t c;
        c = UCODE_NOP;
        unique case (step)
            4'd0:
            begin
                c.acc_op = ACC_LOAD_V;
                c.mul_en = 1'b1; c.pos = POS_A1; c.src = SRC_W1;
            end
            4'd1:
            begin
                c.mul_en = 1'b1; c.mul_hi = 1'b1; c.pos = POS_A1; c.src = SRC_W1;
                c.lo_en  = 1'b1;
            end
            4'd2:
            begin
                c.sum_en = 1'b1;
                c.mul_en = 1'b1; c.pos = POS_A2; c.src = SRC_W2;
            end
            4'd3:
            begin
                c.acc_op = ACC_SUB;
                c.mul_en = 1'b1; c.mul_hi = 1'b1; c.pos = POS_A2; c.src = SRC_W2;
                c.lo_en  = 1'b1;
            end
            4'd4:
            begin
                c.sum_en = 1'b1;
                c.mul_en = 1'b1; c.pos = POS_B1; c.src = SRC_W1;
            end
            4'd5:
            begin
                c.acc_op = ACC_SUB;
                c.mul_en = 1'b1; c.mul_hi = 1'b1; c.pos = POS_B1; c.src = SRC_W1;
                c.lo_en  = 1'b1;
            end
            4'd6:
            begin
                c.sum_en = 1'b1;
                c.w_sat  = 1'b1;
                c.acc_op = ACC_ZERO;
                c.mul_en = 1'b1; c.pos = POS_B2; c.src = SRC_W2;
            end
            4'd7:
            begin
                c.acc_op = ACC_ADD;
                c.mul_en = 1'b1; c.mul_hi = 1'b1; c.pos = POS_B2; c.src = SRC_W2;
                c.lo_en  = 1'b1;
            end
            4'd8:
            begin
                c.sum_en = 1'b1;
                c.mul_en = 1'b1; c.pos = POS_B0; c.src = SRC_W;
            end
            4'd9:
            begin
                c.acc_op = ACC_ADD;
                c.mul_en = 1'b1; c.mul_hi = 1'b1; c.pos = POS_B0; c.src = SRC_W;
                c.lo_en  = 1'b1;
            end
            4'd10:
            begin
                c.sum_en = 1'b1;
            end
            4'd11:
            begin
                c.acc_op = ACC_ADD;
            end
            4'd12:
            begin
                c.stage_end = 1'b1;
                c.jump      = JMP_LOOP;
                c.target    = STEP_STAGE_START;
            end
            4'd13:
            begin
                c.jump = JMP_END;
            end
            default:
            begin
                c.jump   = JMP_LOOP;
                c.target = STEP_STAGE_START;
            end
        endcase
        return c;
    endfunction

endpackage

### rtl/cascaded_biquad_filter_core.sv
// ----------------------------------------------------------------------------
// Cascaded biquad filter core
// Cascade of direct form II second-order sections with a loadable Q2.30
// coefficient table, 48-bit internal words and a saturated sample output.
//
//   Channel   Handshake            Payload    Moves
//   req       req_valid/req_stall  req_item   sample or coefficient write
//   rsp       rsp_valid/rsp_stall  rsp_item   filtered sample, one per sample
//
// A sample item steps through the program once per section and then a final
// step, paced by the single shared multiplier. A coefficient item is written
// in the cycle it is accepted if its index fits the table; it gives no item.
// Reset clears the coefficient table and all delay words to zero.
// The next item is accepted while a result waits in the output register;
// a sample finishes only once that register is free.
// ----------------------------------------------------------------------------
module cascaded_biquad_filter_core #(
    parameter int STAGES = cbq_pkg::STAGES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  cbq_pkg::in_item_t  req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cbq_pkg::out_item_t rsp_item
);
    import cbq_pkg::*;

    localparam int STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;

    logic                          accept;
    logic                          accept_sample;
    logic                          accept_coef;
    logic                          rsp_valid_reg, rsp_valid_next;
    out_item_t                     rsp_item_reg;
    logic                          blk_reg;
    ucode_t                        ctrl;
    logic [STAGE_W-1:0]            stage;
    seq_status_t                   seq_stat;
    logic signed [SAMPLE_BITS-1:0] dp_sample;
    logic                          dp_clipped;

    assign req_stall     = seq_stat.busy;
    assign accept        = req_valid && !req_stall;
    assign accept_sample = accept && (req_item.action == ACT_SAMPLE);
    assign accept_coef   = accept && (req_item.action == ACT_COEF);

    cbq_sequencer #(
        .STAGES (STAGES)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept_sample),
        .hold   (rsp_valid_reg && rsp_stall),
        .ctrl   (ctrl),
        .stage  (stage),
        .status (seq_stat)
    );

    cbq_datapath #(
        .STAGES (STAGES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_we    (accept_coef),
        .coef_index (req_item.coef_index),
        .coef_value (req_item.coef_value),
        .load       (accept_sample),
        .sample_in  (req_item.sample_in),
        .ctrl       (ctrl),
        .stage      (stage),
        .sample_out (dp_sample),
        .clipped    (dp_clipped)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (seq_stat.done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_sample)
        begin
            blk_reg <= req_item.block_end;
        end
        if (seq_stat.done)
        begin
            rsp_item_reg.sample_out    <= dp_sample;
            rsp_item_reg.clipped       <= dp_clipped;
            rsp_item_reg.block_end_out <= blk_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        seq_stat.done |-> !(rsp_valid_reg && rsp_stall))
        else $error("result finished while the output register was still stalled");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept_sample |=> seq_stat.busy)
        else $error("sample item accepted but the sequencer did not start");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(seq_stat.busy) |-> $past(accept_sample))
        else $error("sequencer started without an accepted sample item");

    a_rsp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(seq_stat.done))
        else $error("result appeared without a finished sample");

endmodule

### rtl/cbq_sequencer.sv
// ----------------------------------------------------------------------------
// Cascaded biquad microcode sequencer
// Step counter, stage counter and control store; issues one control word
// per cycle and loops the stage program once for every section.
// ----------------------------------------------------------------------------
module cbq_sequencer #(
    parameter int STAGES = cbq_pkg::STAGES_DEFAULT
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           start,
    input  logic                                           hold,
    output cbq_pkg::ucode_t                                ctrl,
    output logic [((STAGES > 1) ? $clog2(STAGES) : 1)-1:0] stage,
    output cbq_pkg::seq_status_t                           status
);
    import cbq_pkg::*;

    localparam int STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam logic [STAGE_W-1:0] STAGE_LAST = STAGE_W'(STAGES - 1);

    seq_state_t            state_reg, state_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic [STAGE_W-1:0]    stage_reg, stage_next;
    ucode_t                word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            step_reg  <= STEP_STAGE_START;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        stage_next  = stage_reg;
        word        = ucode_rom(step_reg);
        ctrl        = UCODE_NOP;
        status.busy = 1'b0;
        status.done = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = SEQ_RUN;
                    step_next  = STEP_STAGE_START;
                    stage_next = '0;
                end
            end
            SEQ_RUN:
            begin
                ctrl        = word;
                status.busy = 1'b1;
                unique case (word.jump)
                    JMP_NEXT:
                    begin
                        step_next = step_reg + STEP_BITS'(1);
                    end
                    JMP_LOOP:
                    begin
                        if (stage_reg == STAGE_LAST)
                        begin
                            step_next = step_reg + STEP_BITS'(1);
                        end
                        else
                        begin
                            stage_next = stage_reg + STAGE_W'(1);
                            step_next  = word.target;
                        end
                    end
                    JMP_END:
                    begin
                        if (!hold)
                        begin
                            status.done = 1'b1;
                            state_next  = SEQ_IDLE;
                            step_next   = STEP_STAGE_START;
                        end
                    end
                    default:
                    begin
                        state_next = SEQ_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign stage = stage_reg;

endmodule

### rtl/cbq_datapath.sv
// ----------------------------------------------------------------------------
// Cascaded biquad datapath
// Coefficient table, delay words, one shared 32x25 multiplier, product
// combine, accumulator with 48-bit saturation and final sample truncation.
// ----------------------------------------------------------------------------
module cbq_datapath #(
    parameter int STAGES = cbq_pkg::STAGES_DEFAULT
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           coef_we,
    input  logic [cbq_pkg::CIDX_BITS-1:0]                  coef_index,
    input  logic signed [cbq_pkg::COEF_BITS-1:0]           coef_value,
    input  logic                                           load,
    input  logic signed [cbq_pkg::SAMPLE_BITS-1:0]         sample_in,
    input  cbq_pkg::ucode_t                                ctrl,
    input  logic [((STAGES > 1) ? $clog2(STAGES) : 1)-1:0] stage,
    output logic signed [cbq_pkg::SAMPLE_BITS-1:0]         sample_out,
    output logic                                           clipped
);
    import cbq_pkg::*;

    localparam int COEF_N  = COEF_PER_STAGE * STAGES;
    localparam int COEF_AW = (COEF_N > 1) ? $clog2(COEF_N) : 1;
    localparam int STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int YW      = WORD_BITS - INT_FRAC;

    logic signed [COEF_BITS-1:0]  coef_reg [COEF_N];
    logic signed [WORD_BITS-1:0]  w1_reg [STAGES];
    logic signed [WORD_BITS-1:0]  w2_reg [STAGES];
    logic signed [WORD_BITS-1:0]  v_reg;
    logic signed [WORD_BITS-1:0]  w_reg;
    logic signed [MUL_BITS-1:0]   mul_reg;
    logic signed [MUL_BITS-1:0]   lo_reg;
    logic signed [TERM_BITS-1:0]  prod_reg;
    logic signed [ACC_BITS-1:0]   acc_reg;
    logic                         clip_reg;

    logic [COEF_AW-1:0]           coef_addr;
    logic signed [COEF_BITS-1:0]  coef_sel;
    logic signed [WORD_BITS-1:0]  operand;
    logic signed [HALF_BITS-1:0]  half;
    logic signed [FULL_BITS-1:0]  full_sum;
    logic                         acc_ovf;
    logic signed [WORD_BITS-1:0]  acc_sat;
    logic signed [YW-1:0]         y_wide;
    logic                         y_ovf;
    logic [STAGE_W-1:0]           st;

    assign st        = stage;
    assign coef_addr = COEF_AW'(int'(st) * COEF_PER_STAGE + int'(ctrl.pos));
    assign coef_sel  = coef_reg[coef_addr];

    always_comb
    begin
        unique case (ctrl.src)
            SRC_W1:  operand = w1_reg[st];
            SRC_W2:  operand = w2_reg[st];
            SRC_W:   operand = w_reg;
            default: operand = w_reg;
        endcase
    end

    assign half = ctrl.mul_hi ? {operand[WORD_BITS-1], operand[WORD_BITS-1:SPLIT_BITS]}
                              : {1'b0, operand[SPLIT_BITS-1:0]};

    assign full_sum = ({{(FULL_BITS-MUL_BITS){mul_reg[MUL_BITS-1]}}, mul_reg} <<< SPLIT_BITS)
                    + {{(FULL_BITS-MUL_BITS){lo_reg[MUL_BITS-1]}}, lo_reg};

    assign acc_ovf = !((&acc_reg[ACC_BITS-1:WORD_BITS-1]) || !(|acc_reg[ACC_BITS-1:WORD_BITS-1]));
    assign acc_sat = acc_ovf ? {acc_reg[ACC_BITS-1], {(WORD_BITS-1){!acc_reg[ACC_BITS-1]}}}
                             : acc_reg[WORD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_N; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (coef_we && (int'(coef_index) < COEF_N))
        begin
            coef_reg[COEF_AW'(coef_index)] <= coef_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                w1_reg[i] <= '0;
                w2_reg[i] <= '0;
            end
        end
        else if (ctrl.stage_end)
        begin
            w2_reg[st] <= w1_reg[st];
            w1_reg[st] <= w_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg <= 1'b0;
        end
        else if (load)
        begin
            clip_reg <= 1'b0;
        end
        else if ((ctrl.w_sat || ctrl.stage_end) && acc_ovf)
        begin
            clip_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            v_reg <= {{(WORD_BITS-SAMPLE_BITS-INT_FRAC){sample_in[SAMPLE_BITS-1]}},
                      sample_in, {INT_FRAC{1'b0}}};
        end
        else if (ctrl.stage_end)
        begin
            v_reg <= acc_sat;
        end
        if (ctrl.w_sat)
        begin
            w_reg <= acc_sat;
        end
        if (ctrl.mul_en)
        begin
            mul_reg <= coef_sel * half;
        end
        if (ctrl.lo_en)
        begin
            lo_reg <= mul_reg;
        end
        if (ctrl.sum_en)
        begin
            prod_reg <= full_sum[FULL_BITS-1:COEF_FRAC];
        end
        unique case (ctrl.acc_op)
            ACC_HOLD:   acc_reg <= acc_reg;
            ACC_LOAD_V: acc_reg <= {{(ACC_BITS-WORD_BITS){v_reg[WORD_BITS-1]}}, v_reg};
            ACC_ZERO:   acc_reg <= '0;
            ACC_ADD:    acc_reg <= acc_reg
                                 + {{(ACC_BITS-TERM_BITS){prod_reg[TERM_BITS-1]}}, prod_reg};
            ACC_SUB:    acc_reg <= acc_reg
                                 - {{(ACC_BITS-TERM_BITS){prod_reg[TERM_BITS-1]}}, prod_reg};
            default:    acc_reg <= acc_reg;
        endcase
    end

    assign y_wide = v_reg[WORD_BITS-1:INT_FRAC];
    assign y_ovf  = !((&y_wide[YW-1:SAMPLE_BITS-1]) || !(|y_wide[YW-1:SAMPLE_BITS-1]));

    assign sample_out = y_ovf ? {y_wide[YW-1], {(SAMPLE_BITS-1){!y_wide[YW-1]}}}
                              : y_wide[SAMPLE_BITS-1:0];
    assign clipped    = clip_reg || y_ovf;

endmodule

### tb/cascaded_biquad_filter_checker.sv
// ----------------------------------------------------------------------------
// Cascaded biquad filter checker
// Watches both channels of the filter core. Every accepted coefficient item
// in range updates a local copy of the table, and every accepted sample
// item is run through a bit-accurate model of the direct form II cascade,
// which queues the expected filtered sample. Each accepted result item is
// compared field by field with the oldest queued sample. The number of
// queued samples and the number of failures are handed to the testbench top.
// ----------------------------------------------------------------------------
module cascaded_biquad_filter_checker #(
    parameter int STAGES = cbq_pkg::STAGES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  cbq_pkg::in_item_t  req_item,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  cbq_pkg::out_item_t rsp_item,
    output int                 pending,
    output int                 mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import cbq_pkg::*;

    localparam int     TABLE_DEPTH = COEF_PER_STAGE * STAGES;
    localparam longint WORD_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint WORD_MIN    = -WORD_MAX - 64'sd1;
    localparam longint OUT_MAX     = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint OUT_MIN     = -OUT_MAX - 64'sd1;

    logic signed [COEF_BITS-1:0] coef_mem [TABLE_DEPTH];
    longint                      w1_mem [STAGES];
    longint                      w2_mem [STAGES];
    out_item_t                   filtered_q [$];
    out_item_t                   want;
    int                          fail_total;

    function automatic longint q30_product(input logic signed [COEF_BITS-1:0] c,
                                           input longint s);
        logic signed [FULL_BITS-1:0] cw;
        logic signed [FULL_BITS-1:0] sw;
        logic signed [FULL_BITS-1:0] prod;
        cw   = c;
        sw   = s;
        prod = cw * sw;
        return longint'(prod >>> COEF_FRAC);
    endfunction

    function automatic longint clamp_word(input longint v, inout logic clip);
        if (v > WORD_MAX)
        begin
            clip = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            clip = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    function automatic out_item_t filter_sample(input in_item_t it);
        out_item_t res;
        logic      clip;
        longint    v;
        longint    w;
        longint    w1;
        longint    w2;
        longint    y;
        int        base;
        clip = 1'b0;
        v    = longint'(it.sample_in) * (64'sd1 <<< INT_FRAC);
        for (int s = 0; s < STAGES; s++)
        begin
            base = s * COEF_PER_STAGE;
            w1   = w1_mem[s];
            w2   = w2_mem[s];
            w    = clamp_word(v - q30_product(coef_mem[base + int'(POS_A1)], w1)
                                - q30_product(coef_mem[base + int'(POS_A2)], w2), clip);
            v    = clamp_word(q30_product(coef_mem[base + int'(POS_B0)], w)
                              + q30_product(coef_mem[base + int'(POS_B1)], w1)
                              + q30_product(coef_mem[base + int'(POS_B2)], w2), clip);
            w2_mem[s] = w1;
            w1_mem[s] = w;
        end
        y = v >>> INT_FRAC;
        if (y > OUT_MAX)
        begin
            y    = OUT_MAX;
            clip = 1'b1;
        end
        if (y < OUT_MIN)
        begin
            y    = OUT_MIN;
            clip = 1'b1;
        end
        res.sample_out    = y[SAMPLE_BITS-1:0];
        res.clipped       = clip;
        res.block_end_out = it.block_end;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                coef_mem[i] = '0;
            for (int i = 0; i < STAGES; i++)
            begin
                w1_mem[i] = 0;
                w2_mem[i] = 0;
            end
            filtered_q.delete();
            fail_total = 0;
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (filtered_q.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected item: sample_out %0d clipped %0b block_end %0b",
                                 rsp_item.sample_out, rsp_item.clipped,
                                 rsp_item.block_end_out);
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (rsp_item.sample_out !== want.sample_out
                        || rsp_item.clipped !== want.clipped
                        || rsp_item.block_end_out !== want.block_end_out)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                     want.sample_out, want.clipped, want.block_end_out,
                                     rsp_item.sample_out, rsp_item.clipped,
                                     rsp_item.block_end_out);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                if (req_item.action == ACT_COEF)
                begin
                    if (req_item.coef_index < TABLE_DEPTH)
                        coef_mem[req_item.coef_index] = req_item.coef_value;
                end
                else
                    filtered_q.push_back(filter_sample(req_item));
            end
            pending    <= filtered_q.size();
            mismatches <= fail_total;
        end
    end

endmodule

### tb/cascaded_biquad_filter_core_tb.sv
// ----------------------------------------------------------------------------
// Cascaded biquad filter core testbench
// Drives sample and coefficient items into the filter core and lets the
// checker predict and compare every filtered sample. A short directed part
// covers sample extremes, writes past the coefficient table, block marks on
// coefficient items and internal saturation through strong feedback. The
// random part loads stable or fully random coefficient sets and then runs
// bursts of samples, with random idling on both channels.
// ----------------------------------------------------------------------------
module cascaded_biquad_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbq_pkg::*;

    localparam int ITEM_TARGET  = 1050;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int IDLE_PERCENT = 14;
    localparam int TABLE_DEPTH  = COEF_PER_STAGE * STAGES_DEFAULT;
    localparam int A2_SPAN      = 966_367_641;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = 32'sh8000_0000;
    localparam logic signed [COEF_BITS-1:0]   COEF_ONE   = 32'sh4000_0000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    in_item_t  req_item;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    out_item_t rsp_item;
    logic      quiet;
    int        pending;
    int        mismatches;
    int        cycles = 0;
    int        counted = 0;

    always #4 clk = ~clk;

    cascaded_biquad_filter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    cascaded_biquad_filter_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_item   (rsp_item),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("cascaded_biquad_filter_core_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);

    function automatic in_item_t sample_item(input logic signed [SAMPLE_BITS-1:0] value,
                                             input logic mark);
        in_item_t it;
        it.action     = ACT_SAMPLE;
        it.sample_in  = value;
        it.coef_index = CIDX_BITS'($urandom);
        it.coef_value = $urandom;
        it.block_end  = mark;
        return it;
    endfunction

    function automatic in_item_t coef_item(input logic [CIDX_BITS-1:0] index,
                                           input logic signed [COEF_BITS-1:0] value,
                                           input logic mark);
        in_item_t it;
        it.action     = ACT_COEF;
        it.sample_in  = SAMPLE_BITS'($urandom);
        it.coef_index = index;
        it.coef_value = value;
        it.block_end  = mark;
        return it;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3, 4: return SAMPLE_BITS'(int'($urandom_range(0, 2000)) - 1000);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send(input in_item_t it);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (it.action == ACT_SAMPLE || it.coef_index < TABLE_DEPTH)
            counted++;
    endtask

    task automatic load_stage(input int stage, input logic wild);
        logic signed [COEF_BITS-1:0] vals [COEF_PER_STAGE];
        longint                      a1;
        longint                      a2;
        longint                      span;
        if (wild)
        begin
            for (int p = 0; p < COEF_PER_STAGE; p++)
                vals[p] = $urandom;
        end
        else
        begin
            for (int p = 0; p <= int'(POS_B2); p++)
                vals[p] = COEF_BITS'(longint'($urandom_range(0, 1 << 30)) - (64'sd1 <<< 29));
            a2   = longint'($urandom_range(0, 2 * A2_SPAN)) - A2_SPAN;
            span = ((64'sd1 <<< 30) + a2) * 95 / 100;
            a1   = longint'($urandom_range(0, 32'(2 * span))) - span;
            vals[POS_A1] = COEF_BITS'(a1);
            vals[POS_A2] = COEF_BITS'(a2);
        end
        for (int p = 0; p < COEF_PER_STAGE; p++)
            send(coef_item(CIDX_BITS'(stage * COEF_PER_STAGE + p), vals[p],
                           1'($urandom_range(0, 1))));
    endtask

    initial
    begin
        int   phase;
        logic wild;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_item  = '0;
        quiet     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(sample_item(SAMPLE_MAX, 1'b1));
        send(sample_item(SAMPLE_MIN, 1'b0));
        send(coef_item(CIDX_BITS'(TABLE_DEPTH), COEF_MAX, 1'b1));
        send(coef_item({CIDX_BITS{1'b1}}, COEF_MIN, 1'b0));
        for (int s = 0; s < STAGES_DEFAULT; s++)
            send(coef_item(CIDX_BITS'(s * COEF_PER_STAGE + int'(POS_B0)), COEF_ONE, 1'b1));
        send(sample_item(SAMPLE_MAX, 1'b0));
        send(sample_item(SAMPLE_MIN, 1'b1));
        send(coef_item(CIDX_BITS'(POS_A1), COEF_MIN, 1'b0));
        send(coef_item(CIDX_BITS'(POS_A2), COEF_MIN, 1'b0));
        repeat (6) send(sample_item(SAMPLE_MAX, 1'b0));
        repeat (2) send(sample_item(SAMPLE_MIN, 1'b1));
        for (int s = 0; s < STAGES_DEFAULT; s++)
            send(coef_item(CIDX_BITS'(s * COEF_PER_STAGE + int'(POS_B0)), COEF_MAX, 1'b0));
        send(sample_item(SAMPLE_MAX, 1'b1));

        counted = 0;
        phase   = 0;
        while (counted < ITEM_TARGET)
        begin
            quiet <= (phase >= 6 && phase < 10);
            wild = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) == 0)
                load_stage($urandom_range(0, STAGES_DEFAULT - 1), wild);
            else
                for (int s = 0; s < STAGES_DEFAULT; s++)
                    load_stage(s, wild);
            if ($urandom_range(0, 2) == 0)
                send(coef_item(CIDX_BITS'($urandom_range(TABLE_DEPTH, 31)), $urandom,
                               1'($urandom_range(0, 1))));
            repeat ($urandom_range(5, 40))
                send(sample_item(random_sample(), $urandom_range(0, 7) == 0));
            phase++;
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("cascaded_biquad_filter_core_tb passed");
        else
            $display("cascaded_biquad_filter_core_tb failed");
        $finish;
    end

endmodule
